// ===== rtl/cma_pkg.sv =====
// Package for the cascaded moving average block.
// Holds default parameter values, port field widths and payload types.
// No dependencies.
`default_nettype none

package cma_pkg;

    localparam int SAMPLE_WINDOW_DEF = 16;
    localparam int MEAN_WINDOW_DEF   = 8;
    localparam int SAMPLE_BITS_DEF   = 14;

    localparam int SAMPLE_W   = 14;
    localparam int MEAN_OUT_W = 14;
    localparam int SUM_OUT_W  = 17;

    typedef logic [SAMPLE_W-1:0]   sample_t;
    typedef logic [MEAN_OUT_W-1:0] mean_out_t;
    typedef logic [SUM_OUT_W-1:0]  sum_out_t;

endpackage

`default_nettype wire

// ===== rtl/cma_sample_if.sv =====
// Input channel of the cascaded moving average: one converter sample per transaction.
// Depends on cma_pkg.
`default_nettype none

interface cma_sample_if;
    import cma_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

`default_nettype wire

// ===== rtl/cma_result_if.sv =====
// Output channel of the cascaded moving average: window mean, mean sum and wrap flag.
// Depends on cma_pkg.
`default_nettype none

interface cma_result_if;
    import cma_pkg::*;

    logic      valid;
    logic      ready;
    mean_out_t window_mean;
    sum_out_t  mean_sum;
    logic      block_done;

    modport source (output valid, output window_mean, output mean_sum, output block_done,
                    input ready);
    modport sink   (input valid, input window_mean, input mean_sum, input block_done,
                    output ready);

endinterface

`default_nettype wire

// ===== rtl/cma_ring_ram.sv =====
// Ring storage with one write and one registered read port, cleared at reset by valid bits.
// Forwards a write to a read of the same entry in the same cycle. No dependencies.
`default_nettype none

module cma_ring_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 14,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] mem_rd_reg;
    logic [WIDTH-1:0] fwd_data_reg;
    logic             fwd_sel_reg;
    logic             hit_sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rd_reg   <= mem_reg[rd_addr];
            fwd_data_reg <= wr_data;
            fwd_sel_reg  <= wr_en && (wr_addr == rd_addr);
            hit_sel_reg  <= valid_reg[rd_addr];
        end
    end

    assign rd_data = fwd_sel_reg ? fwd_data_reg : (hit_sel_reg ? mem_rd_reg : '0);

endmodule

`default_nettype wire

// ===== rtl/cascaded_moving_average.sv =====
// Top level of the cascaded moving average: sample ring, mean ring and running sums.
// Depends on cma_pkg, cma_sample_if, cma_result_if and cma_ring_ram.
//
//   channel   modport  payload                              transaction
//   samples   sink     sample[13:0]                         valid && ready
//   results   source   window_mean[13:0] mean_sum[16:0]     valid && ready
//                      block_done
//
// One sample per cycle sustained; a result is formed in steps after its sample:
// ring read at acceptance, sum update and ring write-back in the update stage,
// then the output register. Reset clears both rings through per-entry valid bits,
// so the block takes samples in the first cycle after reset. A stalled output
// holds the update stage; the input stalls only when both stages are full.
`default_nettype none

module cascaded_moving_average #(
    parameter int SAMPLE_WINDOW = cma_pkg::SAMPLE_WINDOW_DEF,
    parameter int MEAN_WINDOW   = cma_pkg::MEAN_WINDOW_DEF,
    parameter int SAMPLE_BITS   = cma_pkg::SAMPLE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    cma_sample_if.sink   samples,
    cma_result_if.source results
);
    import cma_pkg::*;

    localparam int SAW   = (SAMPLE_WINDOW > 1) ? $clog2(SAMPLE_WINDOW) : 1;
    localparam int MAW   = (MEAN_WINDOW > 1) ? $clog2(MEAN_WINDOW) : 1;
    localparam int SUM_W = SAMPLE_BITS + $clog2(SAMPLE_WINDOW);
    localparam int TOT_W = SAMPLE_BITS + $clog2(MEAN_WINDOW);
    localparam int DIV_L = $clog2(SAMPLE_WINDOW);
    localparam int DIV_S = SUM_W + DIV_L;
    localparam int RCP_W = SUM_W + 1;
    localparam int PRD_W = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] DIV_RCP =
        RCP_W'(((64'd1 << DIV_S) + 64'(SAMPLE_WINDOW) - 64'd1) / 64'(SAMPLE_WINDOW));

    logic                   s1_valid_reg,  s1_valid_next;
    logic                   s1_wrap_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [SAW-1:0]         s1_slot_reg;
    logic [SAW-1:0]         slot_reg,      slot_next;
    logic [MAW-1:0]         mslot_reg,     mslot_next;
    logic [SUM_W-1:0]       sum_reg,       sum_next;
    logic [TOT_W-1:0]       total_reg,     total_next;
    logic                   out_valid_reg, out_valid_next;
    mean_out_t              out_mean_reg;
    sum_out_t               out_sum_reg;
    logic                   out_done_reg;

    logic                   out_free;
    logic                   s1_adv;
    logic                   accept;
    logic                   push_now;
    logic                   wrap_now;
    logic [SAMPLE_BITS-1:0] s_in;
    logic [SAW-1:0]         slot_inc;
    logic [MAW-1:0]         mslot_inc;
    logic [MAW-1:0]         mean_rd_addr;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [SAMPLE_BITS-1:0] old_mean;
    logic [SAMPLE_BITS-1:0] latest_mean;

    function automatic logic [SAMPLE_BITS-1:0] window_div(input logic [SUM_W-1:0] sum);
        logic [PRD_W-1:0] prod;
        prod = PRD_W'(sum) * PRD_W'(DIV_RCP);
        return prod[DIV_S +: SAMPLE_BITS];
    endfunction

    assign out_free      = !out_valid_reg || results.ready;
    assign s1_adv        = s1_valid_reg && out_free;
    assign samples.ready = !s1_valid_reg || out_free;
    assign accept        = samples.valid && samples.ready;
    assign push_now      = s1_adv && s1_wrap_reg;

    assign s_in         = SAMPLE_BITS'(samples.sample);
    assign wrap_now     = (slot_reg == SAW'(SAMPLE_WINDOW - 1));
    assign slot_inc     = wrap_now ? '0 : slot_reg + 1'b1;
    assign mslot_inc    = (mslot_reg == MAW'(MEAN_WINDOW - 1)) ? '0 : mslot_reg + 1'b1;
    assign mean_rd_addr = push_now ? mslot_inc : mslot_reg;
    assign latest_mean  = window_div(sum_reg);

    cma_ring_ram #(
        .DEPTH (SAMPLE_WINDOW),
        .WIDTH (SAMPLE_BITS),
        .AW    (SAW)
    ) u_sample_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (slot_reg),
        .rd_data (old_sample),
        .wr_en   (s1_adv),
        .wr_addr (s1_slot_reg),
        .wr_data (s1_sample_reg)
    );

    cma_ring_ram #(
        .DEPTH (MEAN_WINDOW),
        .WIDTH (SAMPLE_BITS),
        .AW    (MAW)
    ) u_mean_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (mean_rd_addr),
        .rd_data (old_mean),
        .wr_en   (push_now),
        .wr_addr (mslot_reg),
        .wr_data (latest_mean)
    );

    always_comb
    begin
        sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'(s1_sample_reg);
        total_next = s1_wrap_reg ? (total_reg - TOT_W'(old_mean) + TOT_W'(latest_mean))
                                 : total_reg;

        slot_next      = accept ? slot_inc : slot_reg;
        mslot_next     = push_now ? mslot_inc : mslot_reg;
        s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
            mslot_reg     <= '0;
            sum_reg       <= '0;
            total_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            slot_reg      <= slot_next;
            mslot_reg     <= mslot_next;
            if (s1_adv)
            begin
                sum_reg   <= sum_next;
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= s_in;
            s1_slot_reg   <= slot_reg;
            s1_wrap_reg   <= wrap_now;
        end
        if (s1_adv)
        begin
            out_mean_reg <= MEAN_OUT_W'(window_div(sum_next));
            out_sum_reg  <= SUM_OUT_W'(total_next);
            out_done_reg <= s1_wrap_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.window_mean = out_mean_reg;
    assign results.mean_sum    = out_sum_reg;
    assign results.block_done  = out_done_reg;

endmodule

`default_nettype wire

// ===== rtl/cma_checker.sv =====
// Port-level checks for the cascaded moving average, bound to the top level.
// Depends on cma_pkg and cascaded_moving_average.
`default_nettype none

module cma_checker #(
    parameter int SAMPLE_WINDOW = cma_pkg::SAMPLE_WINDOW_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              out_done,
    input cma_pkg::sum_out_t out_sum
);
    import cma_pkg::*;

    localparam int PW = (SAMPLE_WINDOW > 1) ? $clog2(SAMPLE_WINDOW) : 1;

    logic           in_acc;
    logic           out_acc;
    logic [1:0]     pending_reg, pending_next;
    logic [PW-1:0]  phase_reg,   phase_next;
    sum_out_t       last_sum_reg, last_sum_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pending_next  = pending_reg + {1'b0, in_acc} - {1'b0, out_acc};
        phase_next    = phase_reg;
        last_sum_next = last_sum_reg;
        if (out_acc)
        begin
            phase_next    = (phase_reg == PW'(SAMPLE_WINDOW - 1)) ? '0 : phase_reg + 1'b1;
            last_sum_next = out_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            phase_reg    <= '0;
            last_sum_reg <= '0;
        end
        else
        begin
            pending_reg  <= pending_next;
            phase_reg    <= phase_next;
            last_sum_reg <= last_sum_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sum) && $stable(out_done))
        else $error("result changed or dropped while stalled");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg == 2'd1 || pending_reg == 2'd2))
        else $error("result without an outstanding sample");

    a_wrap_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (out_done == (phase_reg == PW'(SAMPLE_WINDOW - 1))))
        else $error("block_done out of step with the sample window");

    a_sum_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !out_done |-> (out_sum == last_sum_reg))
        else $error("mean_sum changed without a push");

endmodule

bind cascaded_moving_average cma_checker #(
    .SAMPLE_WINDOW (SAMPLE_WINDOW)
) u_cma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_done  (results.block_done),
    .out_sum   (results.mean_sum)
);

`default_nettype wire

// ===== tb/tb_cascaded_moving_average.sv =====
`timescale 1ns / 100ps
// Testbench for cascaded_moving_average: directed, random and back-pressure sample streams,
// each result checked against a cycle-free model of the two boxcar rings.
// Depends on cma_pkg, cma_sample_if, cma_result_if and the block itself.

module tb_cascaded_moving_average;
    import cma_pkg::*;

    localparam int SAMPLE_WINDOW = SAMPLE_WINDOW_DEF;
    localparam int MEAN_WINDOW   = MEAN_WINDOW_DEF;
    localparam int SAMPLE_BITS   = SAMPLE_BITS_DEF;
    localparam int SUM_W         = $clog2(SAMPLE_WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int TOTAL_W       = $clog2(MEAN_WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int FULL_SCALE    = (1 << SAMPLE_W) - 1;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 1190;
    localparam int PRESSURE_HOLD = 200;

    typedef struct packed {
        mean_out_t window_mean;
        sum_out_t  mean_sum;
        logic      block_done;
    } avg_result_t;

    typedef enum int {
        MODE_UNIFORM,
        MODE_FULL,
        MODE_ZERO,
        MODE_LOW,
        MODE_HIGH,
        MODE_ONE_BIT
    } stream_mode_t;

    logic clk;
    logic rst_n;

    cma_sample_if sample_ch ();
    cma_result_if result_ch ();

    cascaded_moving_average #(
        .SAMPLE_WINDOW (SAMPLE_WINDOW),
        .MEAN_WINDOW   (MEAN_WINDOW),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch)
    );

    sample_t              sample_hist [SAMPLE_WINDOW];
    logic [SUM_W-1:0]     sample_total;
    int                   sample_pos;
    mean_out_t            held_mean;
    mean_out_t            mean_hist [MEAN_WINDOW];
    logic [TOTAL_W-1:0]   mean_total;
    int                   mean_pos;

    avg_result_t expected_results [$];

    int  mismatch_count;
    int  samples_sent;
    int  results_seen;
    int  wraps_seen;
    int  hold_request;
    int  longest_hold;
    bit  tx_gaps_on;
    bit  rx_stalls_on;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic avg_result_t predict_average(sample_t raw);
        avg_result_t res;
        sample_t     s;
        s = raw & sample_t'((1 << SAMPLE_BITS) - 1);
        res.block_done = 1'b0;
        sample_total = sample_total - sample_hist[sample_pos] + s;
        sample_hist[sample_pos] = s;
        sample_pos++;
        if (sample_pos >= SAMPLE_WINDOW)
        begin
            sample_pos = 0;
            res.block_done = 1'b1;
            mean_total = mean_total - mean_hist[mean_pos] + held_mean;
            mean_hist[mean_pos] = held_mean;
            mean_pos = (mean_pos + 1) % MEAN_WINDOW;
        end
        held_mean = mean_out_t'(sample_total / SAMPLE_WINDOW);
        res.window_mean = held_mean;
        res.mean_sum = sum_out_t'(mean_total);
        return res;
    endfunction

    task automatic send_sample(input sample_t s);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        do
            @(posedge clk);
        while (!(sample_ch.valid && sample_ch.ready));
        expected_results.push_back(predict_average(s));
        samples_sent++;
    endtask

    function automatic sample_t draw_sample(stream_mode_t mode);
        case (mode)
            MODE_FULL:     return sample_t'(FULL_SCALE);
            MODE_ZERO:     return '0;
            MODE_LOW:      return sample_t'($urandom_range(0, 15));
            MODE_HIGH:     return sample_t'(FULL_SCALE - $urandom_range(0, 15));
            MODE_ONE_BIT:  return sample_t'(1 << $urandom_range(0, SAMPLE_W - 1));
            default:       return sample_t'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    task automatic test_directed();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        send_sample('0);
        send_sample(sample_t'(FULL_SCALE));
        send_sample(sample_t'(14'h2AAA));
        send_sample(sample_t'(14'h1555));
        // fill the rest of the first window at full scale to reach the first wrap
        repeat (SAMPLE_WINDOW - 4) send_sample(sample_t'(FULL_SCALE));
        send_sample(sample_t'(FULL_SCALE));
        send_sample('0);
        send_sample(sample_t'(1));
        send_sample(sample_t'(FULL_SCALE - 1));
    endtask

    task automatic test_random();
        int           run_len;
        int           sent;
        stream_mode_t mode;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode = stream_mode_t'($urandom_range(0, 9) < 5 ? MODE_UNIFORM
                                                           : $urandom_range(1, 5));
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 160)
                                                  : $urandom_range(1, 24);
            if (run_len > RANDOM_ITEMS - sent)
                run_len = RANDOM_ITEMS - sent;
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            repeat (run_len) send_sample(draw_sample(mode));
            sent += run_len;
        end
    endtask

    task automatic test_backpressure();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        hold_request = PRESSURE_HOLD;
        repeat (40) send_sample(sample_t'($urandom_range(0, FULL_SCALE)));
        rx_stalls_on = 1'b1;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        avg_result_t got;
        avg_result_t want;
        int          stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                got.window_mean = result_ch.window_mean;
                got.mean_sum    = result_ch.mean_sum;
                got.block_done  = result_ch.block_done;
                results_seen++;
                if (got.block_done)
                    wraps_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result mean=%0d sum=%0d done=%0b",
                                 $realtime, got.window_mean, got.mean_sum, got.block_done);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.window_mean !== want.window_mean || got.mean_sum !== want.mean_sum
                        || got.block_done !== want.block_done)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $write("%0t: result %0d expected mean=%0d sum=%0d done=%0b,",
                                   $realtime, results_seen, want.window_mean, want.mean_sum,
                                   want.block_done);
                            $display(" got mean=%0d sum=%0d done=%0b",
                                     got.window_mean, got.mean_sum, got.block_done);
                        end
                    end
                end
            end
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                if (stall_left > longest_hold)
                    longest_hold = stall_left;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (rx_stalls_on)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles, %0d results pending",
                         idle, expected_results.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n            <= 1'b0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        foreach (sample_hist[i])
            sample_hist[i] = '0;
        foreach (mean_hist[i])
            mean_hist[i] = '0;
        sample_total   = '0;
        sample_pos     = 0;
        held_mean      = '0;
        mean_total     = '0;
        mean_pos       = 0;
        mismatch_count = 0;
        samples_sent   = 0;
        results_seen   = 0;
        wraps_seen     = 0;
        hold_request   = 0;
        longest_hold   = 0;
        tx_gaps_on     = 1'b0;
        rx_stalls_on   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        test_backpressure();

        sample_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d samples, %0d results, %0d wraps, output held up to %0d cycles",
                 samples_sent, results_seen, wraps_seen, longest_hold);
        $display("Mismatches: %0d, results still pending: %0d",
                 mismatch_count, expected_results.size());
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
